// ===== design/spectral_transient_gate_defines.svh =====
// Assertion macros for the spectral transient gate.
// Used by spectral_transient_gate.sv; needs clk_i and rst_ni in scope.
`ifndef SPECTRAL_TRANSIENT_GATE_DEFINES_SVH
`define SPECTRAL_TRANSIENT_GATE_DEFINES_SVH

// same-cycle implication
`define STG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define STG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/stg_pkg.sv =====
// Package for the spectral transient gate: widths, register codes,
// reset values and the CORDIC arctangent table. No dependencies.
package stg_pkg;

  localparam int SW          = 24;
  localparam int TURN_BITS   = 24;
  localparam int CORDIC_STEPS = 24;
  localparam int CW          = 52;
  localparam int CFG_W       = 17;
  localparam int MAX_LOG2    = 12;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_MIX       = 2'd1;
  localparam logic [1:0] CFG_FRAME_LOG2 = 2'd2;

  localparam logic [16:0] THRESHOLD_RST = 17'd32768;
  localparam logic [16:0] MIX_RST       = 17'd32768;
  localparam logic [3:0]  FRAME_LOG2_RST = 4'd10;

  function automatic logic [TURN_BITS-1:0] atan_lut(input logic [4:0] idx);
    logic [TURN_BITS-1:0] v;
    unique case (idx)
      5'd0:  v = 24'd2097152;
      5'd1:  v = 24'd1238021;
      5'd2:  v = 24'd654136;
      5'd3:  v = 24'd332050;
      5'd4:  v = 24'd166669;
      5'd5:  v = 24'd83416;
      5'd6:  v = 24'd41718;
      5'd7:  v = 24'd20860;
      5'd8:  v = 24'd10430;
      5'd9:  v = 24'd5215;
      5'd10: v = 24'd2608;
      5'd11: v = 24'd1304;
      5'd12: v = 24'd652;
      5'd13: v = 24'd326;
      5'd14: v = 24'd163;
      5'd15: v = 24'd81;
      5'd16: v = 24'd41;
      5'd17: v = 24'd20;
      5'd18: v = 24'd10;
      5'd19: v = 24'd5;
      5'd20: v = 24'd3;
      5'd21: v = 24'd1;
      5'd22: v = 24'd1;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/spectral_transient_gate.sv =====
// Spectral transient gate top level: sequencer around one shared multiplier,
// a CORDIC phase unit and a bit-serial square root. Uses stg_pkg and the
// assertion macros in spectral_transient_gate_defines.svh.
//
// Usage: one complex bin per input transaction (in_re_i, in_im_i, frame_end_i)
// on a valid/ready channel; one result transaction per bin on the output
// channel. Registers are written through cfg_we_i/cfg_addr_i/cfg_wdata_i
// by the user while the block is idle; the block itself does not enforce this.
// Processing steps: the magnitude squares, the bit-serial square root, the log
// mantissa normalization (its length set by the magnitude), the twenty log
// squarings and the log scaling, gain and output stages; the squarings and
// scalings go through the single 32x32 multiplier and its output register,
// and the CORDIC runs alongside. in_ready_o is low while an item is at work,
// so a new item is accepted only after the last one has left the final step.
// The result sits in an output register; the next item may be accepted while
// it waits. If the receiver stalls, the finished next item holds in the final
// step until the output register is free.
// Reset: registers take their reset values, frame position and previous
// phase clear to zero, both channels idle.
`include "spectral_transient_gate_defines.svh"

module spectral_transient_gate (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_addr_i,
  input  logic [stg_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [stg_pkg::SW-1:0] in_re_i,
  input  logic signed [stg_pkg::SW-1:0] in_im_i,
  input  logic                          frame_end_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [stg_pkg::SW-1:0] out_re_o,
  output logic signed [stg_pkg::SW-1:0] out_im_o,
  output logic [11:0]                   hist_index_o,
  output logic [19:0]                   hist_weight_o,
  output logic                          hist_valid_o,
  output logic                          is_transient_o,
  output logic                          out_last_o
);
  import stg_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SQRE  = 5'd1;
  localparam logic [4:0] S_SQIM  = 5'd2;
  localparam logic [4:0] S_SQSUM = 5'd3;
  localparam logic [4:0] S_SQRT  = 5'd4;
  localparam logic [4:0] S_XMUL  = 5'd5;
  localparam logic [4:0] S_XLD   = 5'd6;
  localparam logic [4:0] S_NORM  = 5'd7;
  localparam logic [4:0] S_LSQ   = 5'd8;
  localparam logic [4:0] S_LCHK  = 5'd9;
  localparam logic [4:0] S_LN    = 5'd10;
  localparam logic [4:0] S_LNW   = 5'd11;
  localparam logic [4:0] S_SCRE  = 5'd12;
  localparam logic [4:0] S_SCIM  = 5'd13;
  localparam logic [4:0] S_SCFIN = 5'd14;
  localparam logic [4:0] S_DONE  = 5'd15;

  logic [4:0] state_q;

  logic [16:0] thr_q, mix_q;
  logic [3:0]  flog_q;

  logic [TURN_BITS-1:0] prev_phase_q;
  logic [11:0]          bin_pos_q;

  logic          re_neg_q, im_neg_q, re_zero_q, last_q, first_q;
  logic [SW-1:0] abs_re_q, abs_im_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_q;

  logic [47:0] sq_n_q, sq_res_q, sq_bit_q, sum_q;
  logic [48:0] sq_rb;
  logic [4:0]  cnt_q;

  logic [37:0] lx_q;
  logic [5:0]  lk_q;
  logic [30:0] ly_q;
  logic [19:0] frac_q;
  logic [31:0] lt;
  logic [23:0] lval;
  logic [36:0] wr;
  logic [19:0] w_q;
  logic        over_q;
  logic [16:0] gain_q;
  logic [16:0] mix_cl;
  logic [20:0] thr9;
  logic [SW-1:0] sre_q, sim_q;

  logic signed [CW-1:0] cx_q, cy_q, cdx, cdy, re_ext, im_ext;
  logic [TURN_BITS-1:0] cz_q;
  logic [4:0]           ccnt_q;

  logic [3:0]           fl;
  logic [TURN_BITS-1:0] phase, diff;
  logic                 accept, out_free;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_o || out_ready_i;

  function automatic logic [SW-1:0] scale_sat(input logic neg, input logic [63:0] p);
    logic [39:0] s;
    logic [24:0] r;
    logic [SW-1:0] v;
    s = p[39:0] + 40'd16384;
    r = s[39:15];
    if (!neg) begin
      v = (r > 25'd8388607) ? 24'h7FFFFF : r[SW-1:0];
    end else begin
      v = (r > 25'd8388608) ? 24'h800000 : (~r[SW-1:0] + 24'd1);
    end
    return v;
  endfunction

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THRESHOLD_RST;
      mix_q  <= MIX_RST;
      flog_q <= FRAME_LOG2_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_THRESHOLD:  thr_q  <= cfg_wdata_i;
        CFG_MIX:        mix_q  <= cfg_wdata_i;
        CFG_FRAME_LOG2: flog_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // shared multiplier
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state_q)
      S_SQRE:         begin mul_a = {8'd0, abs_re_q}; mul_b = {8'd0, abs_re_q}; end
      S_SQIM:         begin mul_a = {8'd0, abs_im_q}; mul_b = {8'd0, abs_im_q}; end
      S_XMUL:         begin mul_a = {8'd0, sq_res_q[23:0]}; mul_b = 32'd10000; end
      S_LSQ:          begin mul_a = {1'b0, ly_q}; mul_b = {1'b0, ly_q}; end
      S_LN:           begin mul_a = {8'd0, lval}; mul_b = LN2_Q32; end
      S_SCRE:         begin mul_a = {8'd0, abs_re_q}; mul_b = {15'd0, gain_q}; end
      S_SCIM:         begin mul_a = {8'd0, abs_im_q}; mul_b = {15'd0, gain_q}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // CORDIC, started at accept
  assign re_ext = CW'(in_re_i);
  assign im_ext = CW'(in_im_i);
  assign cdx    = cy_q >>> ccnt_q;
  assign cdy    = cx_q >>> ccnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ccnt_q <= 5'(CORDIC_STEPS);
    end else if (accept) begin
      ccnt_q <= 5'd0;
    end else if (ccnt_q < 5'(CORDIC_STEPS)) begin
      ccnt_q <= ccnt_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (in_re_i < 0) begin
        cx_q <= (-re_ext) <<< 24;
        cy_q <= (-im_ext) <<< 24;
        cz_q <= 24'h800000;
      end else begin
        cx_q <= re_ext <<< 24;
        cy_q <= im_ext <<< 24;
        cz_q <= '0;
      end
    end else if (ccnt_q < 5'(CORDIC_STEPS)) begin
      if (!cy_q[CW-1]) begin
        cx_q <= cx_q + cdx;
        cy_q <= cy_q - cdy;
        cz_q <= cz_q + atan_lut(ccnt_q);
      end else begin
        cx_q <= cx_q - cdx;
        cy_q <= cy_q + cdy;
        cz_q <= cz_q - atan_lut(ccnt_q);
      end
    end
  end

  // datapath helpers
  assign sq_rb  = {1'b0, sq_res_q} + {1'b0, sq_bit_q};
  assign lt     = prod_q[61:30];
  assign lval   = {4'(lk_q - 6'd23), frac_q};
  assign wr     = prod_q[63:36] + {27'd0, prod_q[35]};
  assign mix_cl = (mix_q > 17'd65536) ? 17'd65536 : mix_q;
  assign thr9   = {4'd0, thr_q} * 21'd9;
  assign fl     = (flog_q > 4'(MAX_LOG2)) ? 4'(MAX_LOG2) :
                  ((flog_q < 4'd2) ? 4'd2 : flog_q);
  assign phase  = re_zero_q ? '0 : cz_q;
  assign diff   = phase - prev_phase_q - 24'h400000;

  // sequencer and item datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          re_neg_q  <= in_re_i[SW-1];
          im_neg_q  <= in_im_i[SW-1];
          re_zero_q <= (in_re_i == 0);
          abs_re_q  <= in_re_i[SW-1] ? SW'(-re_ext) : SW'(re_ext);
          abs_im_q  <= in_im_i[SW-1] ? SW'(-im_ext) : SW'(im_ext);
          last_q    <= frame_end_i;
          first_q   <= (bin_pos_q == 12'd0);
        end
      end
      S_SQIM: sum_q <= prod_q[47:0];
      S_SQSUM: begin
        sq_n_q   <= sum_q + prod_q[47:0];
        sq_res_q <= '0;
        sq_bit_q <= 48'h4000_0000_0000;
        cnt_q    <= 5'd0;
      end
      S_SQRT: begin
        if ({1'b0, sq_n_q} >= sq_rb) begin
          sq_n_q   <= sq_n_q - sq_rb[47:0];
          sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
        end else begin
          sq_res_q <= sq_res_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
        cnt_q    <= cnt_q + 5'd1;
      end
      S_XLD: begin
        lx_q <= prod_q[37:0] + 38'd8388608;
        lk_q <= 6'd37;
      end
      S_NORM: begin
        if (lx_q[37]) begin
          ly_q   <= lx_q[37:7];
          frac_q <= '0;
          cnt_q  <= 5'd0;
        end else begin
          lx_q <= lx_q << 1;
          lk_q <= lk_q - 6'd1;
        end
      end
      S_LCHK: begin
        ly_q   <= lt[31] ? lt[31:1] : lt[30:0];
        frac_q <= {frac_q[18:0], lt[31]};
        cnt_q  <= cnt_q + 5'd1;
      end
      S_LNW: begin
        w_q    <= (wr > 37'hFFFFF) ? 20'hFFFFF : wr[19:0];
        over_q <= !first_q && (((wr > 37'hFFFFF) ? 21'hFFFFF : {1'b0, wr[19:0]}) > thr9);
        gain_q <= (!first_q && (((wr > 37'hFFFFF) ? 21'hFFFFF : {1'b0, wr[19:0]}) > thr9))
                  ? (17'd65536 - mix_cl) : mix_cl;
      end
      S_SCIM:  sre_q <= scale_sat(re_neg_q, prod_q);
      S_SCFIN: sim_q <= scale_sat(im_neg_q, prod_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE:  if (accept) state_q <= S_SQRE;
        S_SQRE:  state_q <= S_SQIM;
        S_SQIM:  state_q <= S_SQSUM;
        S_SQSUM: state_q <= S_SQRT;
        S_SQRT:  if (cnt_q == 5'd23) state_q <= S_XMUL;
        S_XMUL:  state_q <= S_XLD;
        S_XLD:   state_q <= S_NORM;
        S_NORM:  if (lx_q[37]) state_q <= S_LSQ;
        S_LSQ:   state_q <= S_LCHK;
        S_LCHK:  state_q <= (cnt_q == 5'd19) ? S_LN : S_LSQ;
        S_LN:    state_q <= S_LNW;
        S_LNW:   state_q <= S_SCRE;
        S_SCRE:  state_q <= S_SCIM;
        S_SCIM:  state_q <= S_SCFIN;
        S_SCFIN: state_q <= S_DONE;
        S_DONE:  if (out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_phase_q <= '0;
      bin_pos_q    <= '0;
    end else if (state_q == S_DONE && out_free) begin
      if (last_q) begin
        prev_phase_q <= '0;
        bin_pos_q    <= '0;
      end else begin
        prev_phase_q <= phase;
        if (bin_pos_q != 12'hFFF) bin_pos_q <= bin_pos_q + 12'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      out_re_o       <= first_q ? '0 : sre_q;
      out_im_o       <= first_q ? '0 : sim_q;
      hist_index_o   <= first_q ? '0 : 12'(diff >> (5'd24 - {1'b0, fl}));
      hist_weight_o  <= first_q ? '0 : w_q;
      hist_valid_o   <= over_q;
      is_transient_o <= over_q;
      out_last_o     <= last_q;
    end
  end

  `STG_ASSERT_NXT(a_busy_after_accept, accept, !in_ready_o)
  `STG_ASSERT_NXT(a_done_loads_out, state_q == S_DONE && out_free, out_valid_o)
  `STG_ASSERT_IMP(a_flags_agree, out_valid_o, hist_valid_o == is_transient_o)
  `STG_ASSERT_NXT(a_frame_clear, state_q == S_DONE && out_free && last_q, bin_pos_q == 12'd0)

endmodule

// ===== test/spectral_transient_gate_tb.sv =====
// Self-checking testbench for spectral_transient_gate: bins go in on a
// valid/ready channel, results are predicted in-bench and checked in order.
// Depends on stg_pkg and the spectral_transient_gate RTL.
`timescale 1ns / 1ps

module spectral_transient_gate_tb;
  import stg_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_CYCLES   = 150;

  typedef struct packed {
    logic signed [SW-1:0] re;
    logic signed [SW-1:0] im;
    logic [11:0]          index;
    logic [19:0]          weight;
    logic                 hvalid;
    logic                 transient;
    logic                 last;
  } bin_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = CFG_THRESHOLD;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SW-1:0] in_re = '0;
  logic signed [SW-1:0] in_im = '0;
  logic frame_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SW-1:0] out_re, out_im;
  logic [11:0] hist_index;
  logic [19:0] hist_weight;
  logic hist_valid, is_transient, out_last;

  spectral_transient_gate DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_addr_i(cfg_addr), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .in_re_i(in_re), .in_im_i(in_im), .frame_end_i(frame_end),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_re_o(out_re), .out_im_o(out_im),
    .hist_index_o(hist_index), .hist_weight_o(hist_weight),
    .hist_valid_o(hist_valid), .is_transient_o(is_transient),
    .out_last_o(out_last)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // gate state mirror
  logic [16:0] threshold_q = THRESHOLD_RST;
  logic [16:0] mix_q = MIX_RST;
  logic [3:0]  frame_log2_q = FRAME_LOG2_RST;
  logic [TURN_BITS-1:0] prev_phase = '0;
  logic [11:0] bin_pos = '0;

  bin_result_t pending_bins[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  function automatic logic [TURN_BITS-1:0] bin_phase(longint re, longint im);
    longint x, y, z, dx, dy;
    if (re == 0) return '0;
    z = 0;
    if (re < 0) begin
      x = -re;
      y = -im;
      z = longint'(1) << (TURN_BITS - 1);
    end else begin
      x = re;
      y = im;
    end
    x = x <<< 24;
    y = y <<< 24;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += longint'(atan_lut(i[4:0]));
      end else begin
        x -= dx;
        y += dy;
        z -= longint'(atan_lut(i[4:0]));
      end
    end
    return z[TURN_BITS-1:0];
  endfunction

  function automatic longint unsigned magnitude(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [19:0] log_weight(longint unsigned mag);
    longint unsigned x, y, frac, l, w;
    int k;
    x = (longint'(1) << (SW - 1)) + 10000 * mag;
    k = 0;
    frac = 0;
    while (k < 63 && (x >> (k + 1)) != 0) k++;
    y = (k >= 30) ? (x >> (k - 30)) : (x << (30 - k));
    for (int i = 0; i < 20; i++) begin
      y = (y * y) >> 30;
      if (y >= (longint'(1) << 31)) begin
        y >>= 1;
        frac |= longint'(1) << (19 - i);
      end
    end
    l = (longint'(k - (SW - 1)) << 20) | frac;
    w = (l * longint'(LN2_Q32) + (longint'(1) << 35)) >> 36;
    if (w > 64'hFFFFF) w = 64'hFFFFF;
    return w[19:0];
  endfunction

  function automatic logic [SW-1:0] apply_gain(longint v, longint unsigned g);
    longint unsigned m;
    longint r;
    m = (v < 0) ? -v : v;
    r = (m * g + (longint'(1) << 14)) >> 15;
    if (v < 0) r = -r;
    if (r > (longint'(1) << (SW - 1)) - 1) r = (longint'(1) << (SW - 1)) - 1;
    if (r < -(longint'(1) << (SW - 1))) r = -(longint'(1) << (SW - 1));
    return r[SW-1:0];
  endfunction

  task automatic predict_bin(logic signed [SW-1:0] re, logic signed [SW-1:0] im,
                             logic last);
    bin_result_t res;
    logic [TURN_BITS-1:0] ph, diff;
    longint unsigned gain, mix;
    logic [19:0] w;
    int fl;
    logic first, over;
    first = (bin_pos == 0);
    fl = frame_log2_q;
    if (fl > MAX_LOG2) fl = MAX_LOG2;
    if (fl < 2) fl = 2;
    ph = bin_phase(re, im);
    diff = ph - prev_phase - (24'd1 << (TURN_BITS - 2));
    prev_phase = ph;
    w = log_weight(magnitude(longint'(re) * re + longint'(im) * im));
    over = !first && (longint'(w) > longint'(threshold_q) * 9);
    mix = (mix_q > 17'd65536) ? 65536 : mix_q;
    gain = over ? 65536 - mix : mix;
    res = '0;
    if (!first) begin
      res.re = apply_gain(re, gain);
      res.im = apply_gain(im, gain);
      res.index = 12'(diff >> (TURN_BITS - fl));
      res.weight = w;
    end
    res.hvalid = over;
    res.transient = over;
    res.last = last;
    pending_bins = {pending_bins, res};
    if (last) begin
      bin_pos = '0;
      prev_phase = '0;
    end else if (bin_pos != 12'hFFF) begin
      bin_pos++;
    end
  endtask

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    bin_result_t exp_r;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_bins.size() == 0) begin
        errors++;
        $display("%0t unexpected transaction re=%0d im=%0d", $time, out_re, out_im);
      end else begin
        exp_r = pending_bins.pop_front();
        if (exp_r.re !== out_re || exp_r.im !== out_im || exp_r.index !== hist_index ||
            exp_r.weight !== hist_weight || exp_r.hvalid !== hist_valid ||
            exp_r.transient !== is_transient || exp_r.last !== out_last) begin
          errors++;
          $display("%0t mismatch exp re=%0d im=%0d idx=%0d w=%0d hv=%0b tr=%0b last=%0b",
                   $time, exp_r.re, exp_r.im, exp_r.index, exp_r.weight,
                   exp_r.hvalid, exp_r.transient, exp_r.last);
          $display("%0t          got re=%0d im=%0d idx=%0d w=%0d hv=%0b tr=%0b last=%0b",
                   $time, out_re, out_im, hist_index, hist_weight,
                   hist_valid, is_transient, out_last);
        end
      end
    end
  end

  task automatic send_bin(logic signed [SW-1:0] re, logic signed [SW-1:0] im,
                          logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_re <= re;
    in_im <= im;
    frame_end <= last;
    do @(posedge clk_i); while (!in_ready);
    predict_bin(re, im, last);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_THRESHOLD:  threshold_q = val;
      CFG_MIX:        mix_q = val;
      CFG_FRAME_LOG2: frame_log2_q = val[3:0];
      default: ;
    endcase
  endtask

  task automatic set_gate(logic [CFG_W-1:0] thr, logic [CFG_W-1:0] mix, logic [3:0] fl);
    wait_drained();
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_MIX, mix);
    write_reg(CFG_FRAME_LOG2, {13'd0, fl});
  endtask

  // magnitudes spread over all octaves so weights straddle the threshold
  function automatic logic signed [SW-1:0] rand_sample();
    logic [SW-1:0] v;
    v = SW'($urandom);
    if ($urandom_range(3) != 0) v = $signed(v) >>> $urandom_range(SW - 1);
    return v;
  endfunction

  task automatic run_random_frames(int n);
    int left;
    left = n;
    while (left > 0) begin
      send_bin(rand_sample(), ($urandom_range(9) == 0) ? '0 : rand_sample(),
               ($urandom_range(7) == 0) || left == 1);
      left--;
    end
  endtask

  task automatic test_directed();
    send_bin(24'sd1000, 24'sd1000, 1'b0);
    send_bin(24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
    send_bin(-24'sh800000, -24'sh800000, 1'b0);
    send_bin(24'sh7FFFFF, -24'sh800000, 1'b0);
    send_bin(-24'sh800000, 24'sh7FFFFF, 1'b0);
    send_bin(24'sd0, 24'sd500000, 1'b0);
    send_bin(24'sd0, -24'sh800000, 1'b0);
    send_bin(24'sd0, 24'sd0, 1'b0);
    send_bin(-24'sd1, 24'sd0, 1'b0);
    send_bin(24'sd1, -24'sd1, 1'b0);
    send_bin(-24'sd300000, 24'sd70000, 1'b1);
    send_bin(24'sh7FFFFF, 24'sd0, 1'b1);
    send_bin(24'sd5, 24'sd5, 1'b0);
    send_bin(-24'sd80000, 24'sd10, 1'b1);
  endtask

  task automatic test_config_extremes();
    set_gate(17'd0, 17'd0, 4'd2);
    test_directed();
    set_gate(17'h1FFFF, 17'd65536, 4'd12);
    test_directed();
    set_gate(17'd1000, 17'h1FFFF, 4'd0);
    test_directed();
    set_gate(17'd20000, 17'd1, 4'd15);
    run_random_frames(40);
    set_gate(17'd26000, 17'd65535, 4'd1);
    run_random_frames(40);
  endtask

  task automatic test_idle_phases();
    set_gate(17'd32768, 17'd20000, 4'd10);
    idle_pct = 0; stall_pct = 0;
    run_random_frames(200);
    set_gate(17'd16384, 17'd50000, 4'd6);
    idle_pct = 86; stall_pct = 0;
    run_random_frames(200);
    set_gate(17'd45000, 17'd131071, 4'd3);
    idle_pct = 0; stall_pct = 86;
    run_random_frames(200);
    set_gate(17'($urandom_range(65536)), 17'($urandom_range(65536)),
             4'($urandom_range(15)));
    idle_pct = 26; stall_pct = 26;
    run_random_frames(200);
  endtask

  task automatic test_long_frame();
    set_gate(17'd30000, 17'd40000, 4'd12);
    idle_pct = 0; stall_pct = 0;
    for (int i = 0; i < 160; i++) send_bin(rand_sample(), rand_sample(), 1'b0);
    send_bin(rand_sample(), rand_sample(), 1'b1);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_idle_phases();
    test_long_frame();
    wait_drained();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/stg_pkg.sv
design/spectral_transient_gate.sv
test/spectral_transient_gate_tb.sv
